// ===== rtl/vies_pkg.sv =====
// Shared types, constants and a helper function for the voxelwise ensemble statistic block.
// No dependencies; every other file in rtl/ but vies_fifo imports this package.
package vies_pkg;

  localparam int NUM_FIELDS     = 8;
  localparam int MAX_IMAGES_DEF = 8;
  localparam int SAMPLE_W       = 16;
  localparam int CENTER_W       = 28;
  localparam int SPREAD_W       = 27;
  localparam int CFG_W          = 28;
  localparam int CFG_IDX_W      = 3;
  localparam int ROOT_BITS      = 27;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPUTE_SPREAD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_ONLY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_VALUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_OUTPUT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGES_IN_USE  = 3'd6;

  // How an item is combined.
  localparam logic [1:0] MODE_MEAN   = 2'd0;
  localparam logic [1:0] MODE_SUM    = 2'd1;
  localparam logic [1:0] MODE_MEDIAN = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SAMPLE_W:0]   key_t;
  typedef key_t keyvec_t [NUM_FIELDS];

  typedef struct packed {
    logic                       median_enable;
    logic                       compute_spread;
    logic                       sum_only;
    logic                       ignore_enable;
    logic signed [SAMPLE_W-1:0] ignore_value;
    logic signed [CENTER_W-1:0] ignore_output;
    logic [3:0]                 images_in_use;
  } cfg_t;

  typedef struct packed {
    logic [3:0] n;
    logic [1:0] mode;
    logic       spread_en;
  } ctl_t;

  typedef struct packed {
    sample_t [NUM_FIELDS-1:0] samples;
    ctl_t                     ctl;
  } item_t;

  typedef struct packed {
    logic signed [CENTER_W-1:0] center;
    logic [SPREAD_W-1:0]        spread;
    logic                       spread_valid;
    logic                       ignored;
  } res_t;

  // ceil(2^34 / (2*n)) for the rounded mean; exact for dividends below 2^29.
  function automatic logic [32:0] recip_q34(input logic [3:0] n);
    logic [32:0] r;
    case (n)
      4'd2:    r = 33'h1_0000_0000;
      4'd3:    r = 33'h0_AAAA_AAAB;
      4'd4:    r = 33'h0_8000_0000;
      4'd5:    r = 33'h0_6666_6667;
      4'd6:    r = 33'h0_5555_5556;
      4'd7:    r = 33'h0_4924_924A;
      4'd8:    r = 33'h0_4000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/vies_fifo.sv =====
// Small register FIFO used between the front and back parts and at the result side.
// Depends on nothing; DEPTH must be a power of two of at least two.
module vies_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  assign rd_data = mem[rd_ptr];
  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);

endmodule

// ===== rtl/vies_front.sv =====
// Front part: configuration registers and classification of each incoming item.
// Depends on vies_pkg.
module vies_front import vies_pkg::*; #(
  parameter int MAX_IMAGES = MAX_IMAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  sample_t [NUM_FIELDS-1:0] samples,
  output item_t                    item,
  output cfg_t                     cfg
);

  localparam logic [3:0] N_LIMIT =
    4'((MAX_IMAGES < NUM_FIELDS) ? MAX_IMAGES : NUM_FIELDS);

  logic [3:0] n;
  logic       hit;
  logic       med;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.median_enable  <= 1'b1;
      cfg.compute_spread <= 1'b0;
      cfg.sum_only       <= 1'b0;
      cfg.ignore_enable  <= 1'b0;
      cfg.ignore_value   <= -16'sd32767;
      cfg.ignore_output  <= '0;
      cfg.images_in_use  <= 4'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MEDIAN_ENABLE:  cfg.median_enable  <= cfg_data[0];
        REG_COMPUTE_SPREAD: cfg.compute_spread <= cfg_data[0];
        REG_SUM_ONLY:       cfg.sum_only       <= cfg_data[0];
        REG_IGNORE_ENABLE:  cfg.ignore_enable  <= cfg_data[0];
        REG_IGNORE_VALUE:   cfg.ignore_value   <= cfg_data[SAMPLE_W-1:0];
        REG_IGNORE_OUTPUT:  cfg.ignore_output  <= cfg_data[CENTER_W-1:0];
        REG_IMAGES_IN_USE:  cfg.images_in_use  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the image count and look for the ignore value among the lanes in use.
  always_comb begin
    if (cfg.images_in_use < 4'd2) n = 4'd2;
    else if (cfg.images_in_use > N_LIMIT) n = N_LIMIT;
    else n = cfg.images_in_use;
    hit = 1'b0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (cfg.ignore_enable && (4'(i) < n) && (samples[i] == cfg.ignore_value)) hit = 1'b1;
    end
    med = cfg.median_enable && (n >= 4'd3) && !cfg.compute_spread;
  end

  // Classified item for the queue.
  always_comb begin
    item.samples = samples;
    item.ctl.n   = n;
    if (hit) item.ctl.mode = MODE_IGNORE;
    else if (med) item.ctl.mode = MODE_MEDIAN;
    else if (cfg.sum_only) item.ctl.mode = MODE_SUM;
    else item.ctl.mode = MODE_MEAN;
    item.ctl.spread_en = cfg.compute_spread && !cfg.sum_only && !hit && !med;
  end

endmodule

// ===== rtl/vies_back.sv =====
// Back part: lockstep pipeline with sums, squares, sorting network, rounded mean
// and a bit-per-stage square root. Depends on vies_pkg.
module vies_back import vies_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t item,
  input  logic  item_avail,
  output logic  item_take,
  input  cfg_t  cfg,
  input  logic  res_room,
  output logic  res_wr,
  output res_t  res
);

  localparam int STEPS = ROOT_BITS;
  localparam key_t PAD = 17'sd32768;

  logic adv;

  // Stage 1: item from the queue.
  logic v1;
  ctl_t c1;
  sample_t [NUM_FIELDS-1:0] smp1;
  // Stage 2: masked lanes, squares, sort keys.
  logic v2;
  ctl_t c2;
  sample_t lane2 [NUM_FIELDS];
  logic [31:0] sq2 [NUM_FIELDS];
  keyvec_t srt2;
  // Stage 3: pair sums.
  logic v3;
  ctl_t c3;
  logic signed [17:0] sp3 [NUM_FIELDS/2];
  logic [32:0] s2p3 [NUM_FIELDS/2];
  keyvec_t srt3;
  // Stage 4: totals.
  logic v4;
  ctl_t c4;
  logic signed [18:0] s4;
  logic [33:0] s24;
  keyvec_t srt4;
  // Stage 5: products and mean dividend.
  logic v5;
  ctl_t c5;
  logic signed [18:0] s5;
  logic [27:0] x5;
  logic neg5;
  logic [37:0] ns25;
  logic signed [37:0] ss5;
  keyvec_t srt5;
  // Stage 6: reciprocal product and spread numerator.
  logic v6;
  ctl_t c6;
  logic signed [18:0] s6;
  logic neg6;
  logic [60:0] qp6;
  logic [36:0] dn6;
  keyvec_t srt6;
  // Square root chain; entry 0 also holds the finished center value.
  logic rv [STEPS+1];
  ctl_t rc [STEPS+1];
  logic signed [CENTER_W-1:0] cen [STEPS+1];
  logic [54:0] rr_rem [STEPS+1];
  logic [STEPS-1:0] rr_root [STEPS+1];
  logic [32:0] rr_d [STEPS+1];
  logic [5:0] rden [STEPS+1];

  // Combinational values between stages.
  sample_t lane_c [NUM_FIELDS];
  logic [31:0] sq_c [NUM_FIELDS];
  keyvec_t srt_c;
  logic signed [18:0] s_c;
  logic [33:0] s2_c;
  logic [18:0] mag_c;
  logic signed [38:0] d_c;
  logic [26:0] q_c;
  logic signed [CENTER_W-1:0] cen_c;
  logic [2:0] hidx;
  logic [2:0] lidx;
  logic signed [17:0] msum;
  logic [7:0] den8;
  logic [54:0] rem_n [STEPS];
  logic [STEPS-1:0] root_n [STEPS];
  logic [32:0] d_n [STEPS];
  logic [27:0] half;
  logic [23:0] m24;

  // One layer of odd-even transposition sort.
  function automatic keyvec_t sort_layer(input keyvec_t a, input int par);
    keyvec_t b;
    b = a;
    for (int i = par; i + 1 < NUM_FIELDS; i += 2) begin
      if (a[i] > a[i+1]) begin
        b[i]   = a[i+1];
        b[i+1] = a[i];
      end
    end
    return b;
  endfunction

  assign adv       = !rv[STEPS] || res_room;
  assign item_take = adv && item_avail;
  assign res_wr    = adv && rv[STEPS];

  // Lane masking and squares.
  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      lane_c[i] = (4'(i) < c1.n) ? smp1[i] : '0;
      sq_c[i]   = 32'(lane_c[i]) * 32'(lane_c[i]);
      srt_c[i]  = (4'(i) < c1.n) ? key_t'(smp1[i]) : PAD;
    end
  end

  // Totals, dividend and spread numerator.
  always_comb begin
    s_c  = '0;
    s2_c = '0;
    for (int i = 0; i < NUM_FIELDS/2; i++) begin
      s_c  = s_c + 19'(sp3[i]);
      s2_c = s2_c + 34'(s2p3[i]);
    end
    mag_c = s4[18] ? 19'(-s4) : 19'(s4);
    d_c   = $signed({1'b0, ns25}) - 39'(ss5);
  end

  // Center value for every mode.
  always_comb begin
    q_c  = qp6[60:34];
    hidx = c6.n[3:1];
    lidx = hidx - 3'd1;
    msum = 18'(srt6[lidx]) + 18'(srt6[hidx]);
    case (c6.mode)
      MODE_IGNORE: cen_c = cfg.ignore_output;
      MODE_SUM:    cen_c = {s6[18], s6, 8'b0};
      MODE_MEDIAN: begin
        if (c6.n[0]) cen_c = {{3{srt6[hidx][16]}}, srt6[hidx], 8'b0};
        else cen_c = {{3{msum[17]}}, msum, 7'b0};
      end
      default:     cen_c = neg6 ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
    endcase
    den8 = 8'(c6.n) * 8'(c6.n - 4'd1);
  end

  // One root bit per chain stage, restoring digit recurrence on den*r^2 <= t.
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      logic [61:0] trial;
      trial = (62'(rr_d[k]) << (STEPS - k)) + (62'(rden[k]) << (2 * (STEPS - 1 - k)));
      rem_n[k]  = rr_rem[k];
      root_n[k] = rr_root[k];
      d_n[k]    = rr_d[k];
      if (trial <= 62'(rr_rem[k])) begin
        rem_n[k]  = rr_rem[k] - trial[54:0];
        root_n[k] = rr_root[k] | (STEPS'(1) << (STEPS - 1 - k));
        d_n[k]    = rr_d[k] + (33'(rden[k]) << (STEPS - 1 - k));
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      for (int k = 0; k <= STEPS; k++) rv[k] <= 1'b0;
    end else if (adv) begin
      v1 <= item_avail;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      rv[0] <= v6;
      for (int k = 0; k < STEPS; k++) rv[k+1] <= rv[k];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      c1   <= item.ctl;
      smp1 <= item.samples;

      c2   <= c1;
      srt2 <= srt_c;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        lane2[i] <= lane_c[i];
        sq2[i]   <= sq_c[i];
      end

      c3   <= c2;
      srt3 <= sort_layer(sort_layer(srt2, 0), 1);
      for (int i = 0; i < NUM_FIELDS/2; i++) begin
        sp3[i]  <= 18'(lane2[2*i]) + 18'(lane2[2*i+1]);
        s2p3[i] <= 33'(sq2[2*i]) + 33'(sq2[2*i+1]);
      end

      c4   <= c3;
      srt4 <= sort_layer(sort_layer(srt3, 0), 1);
      s4   <= s_c;
      s24  <= s2_c;

      c5   <= c4;
      srt5 <= sort_layer(sort_layer(srt4, 0), 1);
      s5   <= s4;
      x5   <= {mag_c, 9'b0} + 28'(c4.n);
      neg5 <= s4[18];
      ns25 <= 38'(c4.n) * 38'(s24);
      ss5  <= 38'(s4) * 38'(s4);

      c6   <= c5;
      srt6 <= sort_layer(sort_layer(srt5, 0), 1);
      s6   <= s5;
      neg6 <= neg5;
      qp6  <= 61'(x5) * 61'(recip_q34(c5.n));
      dn6  <= d_c[38] ? '0 : d_c[36:0];

      rc[0]      <= c6;
      cen[0]     <= cen_c;
      rr_rem[0]  <= {dn6, 18'b0};
      rr_root[0] <= '0;
      rr_d[0]    <= '0;
      rden[0]    <= den8[5:0];
      for (int k = 0; k < STEPS; k++) begin
        rc[k+1]      <= rc[k];
        cen[k+1]     <= cen[k];
        rr_rem[k+1]  <= rem_n[k];
        rr_root[k+1] <= root_n[k];
        rr_d[k+1]    <= d_n[k];
        rden[k+1]    <= rden[k];
      end
    end
  end

  // Result: round the root to Q19.8 and saturate to 24 bits.
  always_comb begin
    half = (28'(rr_root[STEPS]) + 28'd1) >> 1;
    m24  = (half[27:24] != '0) ? 24'hFF_FFFF : half[23:0];
    res.center       = cen[STEPS];
    res.spread_valid = rc[STEPS].spread_en;
    res.spread       = rc[STEPS].spread_en ? SPREAD_W'(m24) : '0;
    res.ignored      = (rc[STEPS].mode == MODE_IGNORE);
  end

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    item_take |=> v1)
    else $error("taken item did not enter stage one");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rv[STEPS] && !res_room) |=> (rv[STEPS] && $stable(cen[STEPS])))
    else $error("last stage changed while stalled");

  a_spread_mode: assert property (@(posedge clk) disable iff (rst)
    (res_wr && res.spread_valid) |-> (rc[STEPS].mode == MODE_MEAN))
    else $error("spread flagged outside mean mode");

endmodule

// ===== rtl/voxelwise_image_ensemble_statistic_top.sv =====
// Top level of the voxelwise ensemble statistic block.
// Depends on vies_pkg, vies_front, vies_fifo and vies_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  input    | push / full             | sample_0 .. sample_7
//  result   | empty / pop             | center_value, spread, spread_valid, ignored
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item per cycle is accepted and one result per cycle delivered when pop keeps up.
// Each item passes six arithmetic and sorting stages, then the 27-stage square root
// chain, before it reaches the result queue. rst is synchronous and clears the queues,
// the pipeline valid bits and the registers to their defaults. A stalled result stalls
// the whole back pipeline; the four-entry queue keeps the input open meanwhile.
module voxelwise_image_ensemble_statistic_top import vies_pkg::*; #(
  parameter int MAX_IMAGES = MAX_IMAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [SAMPLE_W-1:0]  sample_0,
  input  logic signed [SAMPLE_W-1:0]  sample_1,
  input  logic signed [SAMPLE_W-1:0]  sample_2,
  input  logic signed [SAMPLE_W-1:0]  sample_3,
  input  logic signed [SAMPLE_W-1:0]  sample_4,
  input  logic signed [SAMPLE_W-1:0]  sample_5,
  input  logic signed [SAMPLE_W-1:0]  sample_6,
  input  logic signed [SAMPLE_W-1:0]  sample_7,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [CENTER_W-1:0]  center_value,
  output logic [SPREAD_W-1:0]         spread,
  output logic                        spread_valid,
  output logic                        ignored,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  sample_t [NUM_FIELDS-1:0] samples;
  item_t front_item;
  item_t mid_item;
  cfg_t  cfg;
  res_t  back_res;
  res_t  out_res;
  logic  mid_full;
  logic  mid_empty;
  logic  mid_take;
  logic  res_wr;
  logic  out_full;

  assign samples   = {sample_7, sample_6, sample_5, sample_4,
                      sample_3, sample_2, sample_1, sample_0};
  assign cfg_ready = 1'b1;
  assign full      = mid_full;

  vies_front #(.MAX_IMAGES(MAX_IMAGES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .item      (front_item),
    .cfg       (cfg)
  );

  // Queue between classification and execution.
  vies_fifo #(.W($bits(item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !mid_full),
    .wr_data (front_item),
    .rd_en   (mid_take),
    .rd_data (mid_item),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  vies_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (mid_item),
    .item_avail (!mid_empty),
    .item_take  (mid_take),
    .cfg        (cfg),
    .res_room   (!out_full),
    .res_wr     (res_wr),
    .res        (back_res)
  );

  // Result queue toward the consumer.
  vies_fifo #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (back_res),
    .rd_en   (pop && !empty),
    .rd_data (out_res),
    .full    (out_full),
    .empty   (empty)
  );

  assign center_value = out_res.center;
  assign spread       = out_res.spread;
  assign spread_valid = out_res.spread_valid;
  assign ignored      = out_res.ignored;

endmodule

// ===== bench/vies_checker.sv =====
`timescale 1ns / 100ps
// Checker for the voxelwise ensemble statistic block: watches the input, result and
// configuration channels, predicts each result and compares it. Depends on vies_pkg.
module vies_checker import vies_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_0,
  input  logic signed [SAMPLE_W-1:0] sample_1,
  input  logic signed [SAMPLE_W-1:0] sample_2,
  input  logic signed [SAMPLE_W-1:0] sample_3,
  input  logic signed [SAMPLE_W-1:0] sample_4,
  input  logic signed [SAMPLE_W-1:0] sample_5,
  input  logic signed [SAMPLE_W-1:0] sample_6,
  input  logic signed [SAMPLE_W-1:0] sample_7,
  input  logic                       empty,
  input  logic                       pop,
  input  logic signed [CENTER_W-1:0] center_value,
  input  logic [SPREAD_W-1:0]        spread,
  input  logic                       spread_valid,
  input  logic                       ignored,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         errors,
  output int                         pending
);

  res_t voxel_results_q[$];
  cfg_t regs;

  // Nearest integer to sqrt(65536*num/den), ties rounded up.
  function automatic logic [SPREAD_W-1:0] spread_root(input longint unsigned num,
                                                      input longint unsigned den);
    longint unsigned t, lo, hi, mid, k;
    t  = num << 18;
    lo = 0;
    hi = (64'd1 << 24) - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      k = 2 * mid - 1;
      if (k * k * den <= t) lo = mid;
      else hi = mid - 1;
    end
    return lo[SPREAD_W-1:0];
  endfunction

  function automatic res_t voxel_statistic(input sample_t s [NUM_FIELDS]);
    res_t r;
    int n;
    longint v [NUM_FIELDS];
    longint x, sum, sq, c, num, d;
    longint unsigned mag, q;
    bit hit;
    int j;
    r = '0;
    hit = 0;
    n = regs.images_in_use;
    if (n < 2) n = 2;
    if (n > NUM_FIELDS) n = NUM_FIELDS;
    for (int i = 0; i < n; i++) begin
      v[i] = s[i];
      if (regs.ignore_enable && s[i] == regs.ignore_value) hit = 1;
    end
    if (hit) begin
      r.center = regs.ignore_output;
      r.ignored = 1;
    end else if (regs.median_enable && n >= 3 && !regs.compute_spread) begin
      for (int i = 1; i < n; i++) begin
        x = v[i];
        j = i - 1;
        while (j >= 0 && v[j] > x) begin
          v[j + 1] = v[j];
          j--;
        end
        v[j + 1] = x;
      end
      if (n % 2) c = v[n / 2] * 256;
      else c = (v[n / 2 - 1] + v[n / 2]) * 128;
      r.center = c[CENTER_W-1:0];
    end else begin
      sum = 0;
      sq = 0;
      for (int i = 0; i < n; i++) begin
        sum += v[i];
        sq += v[i] * v[i];
      end
      if (regs.sum_only) c = sum * 256;
      else begin
        num = sum * 256;
        mag = num < 0 ? -num : num;
        q = (2 * mag + n) / (2 * n);
        c = num < 0 ? -longint'(q) : longint'(q);
      end
      r.center = c[CENTER_W-1:0];
      if (regs.compute_spread && !regs.sum_only) begin
        d = n * sq - sum * sum;
        r.spread = spread_root(d < 0 ? 0 : d, n * (n - 1));
        r.spread_valid = 1;
      end
    end
    return r;
  endfunction

  assign pending = voxel_results_q.size();

  always @(posedge clk) begin
    sample_t s [NUM_FIELDS];
    res_t want;
    if (rst) begin
      regs <= '{median_enable: 1'b1, compute_spread: 1'b0, sum_only: 1'b0,
                ignore_enable: 1'b0, ignore_value: -16'sd32767, ignore_output: '0,
                images_in_use: 4'd8};
      voxel_results_q.delete();
      errors <= 0;
    end else begin
      // Input transaction: predict with the settings in force now.
      if (push && !full) begin
        s = '{sample_0, sample_1, sample_2, sample_3,
              sample_4, sample_5, sample_6, sample_7};
        voxel_results_q.push_back(voxel_statistic(s));
      end
      // Result transaction.
      if (pop && !empty) begin
        if (voxel_results_q.size() == 0) begin
          $display("%0t: unexpected result center=%0d", $time, center_value);
          errors <= errors + 1;
        end else begin
          want = voxel_results_q.pop_front();
          if (want.center !== center_value || want.spread !== spread ||
              want.spread_valid !== spread_valid || want.ignored !== ignored) begin
            $display("%0t: mismatch expected c=%0d s=%0d sv=%0b ig=%0b got c=%0d s=%0d sv=%0b ig=%0b",
                     $time, want.center, want.spread, want.spread_valid, want.ignored,
                     center_value, spread, spread_valid, ignored);
            errors <= errors + 1;
          end
        end
      end
      // Configuration transaction.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MEDIAN_ENABLE:  regs.median_enable  <= cfg_data[0];
          REG_COMPUTE_SPREAD: regs.compute_spread <= cfg_data[0];
          REG_SUM_ONLY:       regs.sum_only       <= cfg_data[0];
          REG_IGNORE_ENABLE:  regs.ignore_enable  <= cfg_data[0];
          REG_IGNORE_VALUE:   regs.ignore_value   <= cfg_data[SAMPLE_W-1:0];
          REG_IGNORE_OUTPUT:  regs.ignore_output  <= cfg_data[CENTER_W-1:0];
          REG_IMAGES_IN_USE:  regs.images_in_use  <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb_voxelwise_image_ensemble_statistic_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the voxelwise ensemble statistic block: drives samples and settings
// and gives the verdict. Depends on vies_pkg, the block's RTL and vies_checker.
module tb_voxelwise_image_ensemble_statistic_top;
  import vies_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic cfg_valid = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  sample_t smp [NUM_FIELDS];
  logic full, empty, cfg_ready, spread_valid, ignored;
  logic signed [CENTER_W-1:0] center_value;
  logic [SPREAD_W-1:0] spread;
  int errors, pending, idle_cycles;
  sample_t ign_val = -16'sd32767;

  always #2 clk = ~clk;

  initial foreach (smp[i]) smp[i] = '0;

  voxelwise_image_ensemble_statistic_top DUT (
    .clk, .rst, .push, .full,
    .sample_0(smp[0]), .sample_1(smp[1]), .sample_2(smp[2]), .sample_3(smp[3]),
    .sample_4(smp[4]), .sample_5(smp[5]), .sample_6(smp[6]), .sample_7(smp[7]),
    .empty, .pop, .center_value, .spread, .spread_valid, .ignored,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  vies_checker checker_i (
    .clk, .rst, .push, .full,
    .sample_0(smp[0]), .sample_1(smp[1]), .sample_2(smp[2]), .sample_3(smp[3]),
    .sample_4(smp[4]), .sample_5(smp[5]), .sample_6(smp[6]), .sample_7(smp[7]),
    .empty, .pop, .center_value, .spread, .spread_valid, .ignored,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // Receiver stalls: long ready and stall runs of varying length.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) pop <= 0;
    else if (r < 8) pop <= ~pop;
    else if (r < 10) pop <= 1;
  end

  // Watchdog on cycles with no transaction of any kind.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Writes one register; the block must be idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_IGNORE_VALUE) ign_val = val[SAMPLE_W-1:0];
    @(posedge clk);
  endtask

  // Sends one voxel; push stays high into the next call.
  task automatic send_voxel(input sample_t s [NUM_FIELDS]);
    push <= 1;
    foreach (s[i]) smp[i] <= s[i];
    do @(posedge clk); while (full);
  endtask

  task automatic gap_maybe();
    if ($urandom_range(0, 9) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(input int style);
    case (style)
      0: return sample_t'($urandom());
      1: return sample_t'($urandom_range(0, 6)) - 3;
      2: return ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      default: return ($urandom_range(0, 3) == 0) ? ign_val : sample_t'($urandom());
    endcase
  endfunction

  task automatic random_phase(input int count);
    sample_t s [NUM_FIELDS];
    int style;
    for (int k = 0; k < count; k++) begin
      style = $urandom_range(0, 5);
      foreach (s[i]) s[i] = rand_sample(style > 3 ? 0 : style);
      send_voxel(s);
      gap_maybe();
    end
    drain();
  endtask

  task automatic random_config();
    write_reg(REG_MEDIAN_ENABLE, $urandom_range(0, 1));
    write_reg(REG_COMPUTE_SPREAD, $urandom_range(0, 1));
    write_reg(REG_SUM_ONLY, $urandom_range(0, 1));
    write_reg(REG_IGNORE_ENABLE, $urandom_range(0, 1));
    write_reg(REG_IGNORE_VALUE, $urandom());
    write_reg(REG_IGNORE_OUTPUT, $urandom());
    write_reg(REG_IMAGES_IN_USE, $urandom_range(0, 15));
  endtask

  initial begin
    sample_t s [NUM_FIELDS];
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes under the reset settings (median of eight).
    foreach (s[i]) s[i] = 16'sh7fff;
    send_voxel(s);
    foreach (s[i]) s[i] = 16'sh8000;
    send_voxel(s);
    foreach (s[i]) s[i] = (i % 2) ? 16'sh7fff : 16'sh8000;
    send_voxel(s);
    foreach (s[i]) s[i] = -16'sd32767;
    send_voxel(s);
    drain();

    // Directed: mean with spread, rounding of positive and negative means, sum, ignore.
    write_reg(REG_COMPUTE_SPREAD, 1);
    write_reg(REG_IMAGES_IN_USE, 3);
    foreach (s[i]) s[i] = 16'sh8000;
    send_voxel(s);
    s[0] = 16'sh7fff;
    send_voxel(s);
    s = '{1, 0, 0, 0, 0, 0, 0, 0};
    send_voxel(s);
    s = '{-1, 0, 0, 0, 0, 0, 0, 0};
    send_voxel(s);
    drain();
    write_reg(REG_SUM_ONLY, 1);
    write_reg(REG_IMAGES_IN_USE, 8);
    foreach (s[i]) s[i] = 16'sh8000;
    send_voxel(s);
    foreach (s[i]) s[i] = 16'sh7fff;
    send_voxel(s);
    drain();
    write_reg(REG_IGNORE_ENABLE, 1);
    write_reg(REG_IGNORE_VALUE, 16'h8000);
    write_reg(REG_IGNORE_OUTPUT, 28'h8000000);
    s = '{5, 6, 7, 8, 9, 10, 11, -16'sd32768};
    send_voxel(s);
    s[7] = 0;
    send_voxel(s);
    drain();
    write_reg(REG_IGNORE_OUTPUT, 28'h7ffffff);
    write_reg(REG_IMAGES_IN_USE, 0);
    s = '{-16'sd32768, 1, 2, 3, 4, 5, 6, 7};
    send_voxel(s);
    drain();
    write_reg(REG_IMAGES_IN_USE, 15);
    send_voxel(s);
    drain();

    // Random phases, each with its own settings.
    for (int p = 0; p < 15; p++) begin
      random_config();
      random_phase($urandom_range(60, 120));
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
